// ----- rtl/bmsrfc_pkg.sv -----
// ----------------------------------------------------------------------------
// bmsrfc_pkg
// Shared types and constants of the battery-monitor reply frame checker.
// ----------------------------------------------------------------------------
`default_nettype none

package bmsrfc_pkg;

    localparam int MAX_FRAME_BYTES_DEF   = 50;
    localparam int CHARGE_BYTE_INDEX_DEF = 23;

    localparam logic [7:0]  HEADER_BYTE       = 8'hDD;
    localparam logic [15:0] VOLT_MIN_RESET    = 16'd4100;
    localparam logic [15:0] VOLT_MAX_RESET    = 16'd6000;
    localparam logic [7:0]  LOW_CHARGE_RESET  = 8'd20;

    typedef enum logic [1:0] {
        STATUS_GOOD       = 2'd0,
        STATUS_BAD_HEADER = 2'd1,
        STATUS_BAD_SUM    = 2'd2,
        STATUS_TOO_LONG   = 2'd3
    } status_t;

    typedef struct packed {
        logic [15:0] volt_min;
        logic [15:0] volt_max;
        logic [7:0]  low_level;
    } cfg_t;

    // end of a frame as seen by the parser
    typedef struct packed {
        logic        fire;
        status_t     status;
        logic [15:0] volt;
        logic [7:0]  charge;
    } frame_event_t;

endpackage

`default_nettype wire

// ----- rtl/bms_reply_frame_checker_unit.sv -----
// ----------------------------------------------------------------------------
// bms_reply_frame_checker_unit
// Checks battery-monitor reply frames byte by byte and reports each frame.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_ready) carries one reply byte per item with
// frame_start marking byte 0. Output channel (out_valid / out_ready) carries
// one result per finished frame: status, kept voltage, filtered charge and
// the low battery flag. A frame whose length byte is too large reports at
// once from its length byte; bytes outside a frame give no result.
// One byte is taken every cycle while the output is not stalled: the byte
// goes into an input register, the frame logic works on it from there and
// writes the result register, which drives out_valid. When the receiver
// stalls with a result pending, the frame logic holds and the input register
// still takes one more byte, then in_ready drops. Reset clears the frame
// tracking, the kept values and both valid bits and loads the register
// defaults; no clearing pass is needed. The config port (cfg_we, cfg_index,
// cfg_wdata) must be written by the user only while idle; nothing enforces it.
// ----------------------------------------------------------------------------
`default_nettype none

module bms_reply_frame_checker_unit
#(
    parameter int MAX_FRAME_BYTES   = bmsrfc_pkg::MAX_FRAME_BYTES_DEF,
    parameter int CHARGE_BYTE_INDEX = bmsrfc_pkg::CHARGE_BYTE_INDEX_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  rx_byte,
    input  wire logic        frame_start,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       frame_status,
    output logic [15:0]      voltage_centivolts,
    output logic [7:0]       charge_percent,
    output logic             low_battery,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_wdata
);

    import bmsrfc_pkg::*;

    logic         in_valid_reg;
    logic [7:0]   byte_reg;
    logic         start_reg;
    logic         advance;
    logic         step;
    cfg_t         cfg;
    frame_event_t ev;

    assign advance  = !out_valid || out_ready;
    assign step     = in_valid_reg && advance;
    assign in_ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg  <= rx_byte;
            start_reg <= frame_start;
        end
    end

    bmsrfc_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    bmsrfc_frame_parser
    #(
        .MAX_FRAME_BYTES   (MAX_FRAME_BYTES),
        .CHARGE_BYTE_INDEX (CHARGE_BYTE_INDEX)
    )
    u_parser
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .rx_byte     (byte_reg),
        .frame_start (start_reg),
        .ev          (ev)
    );

    bmsrfc_result_stage u_result
    (
        .clk                (clk),
        .rst_n              (rst_n),
        .step               (step),
        .advance            (advance),
        .ev                 (ev),
        .cfg                (cfg),
        .out_valid          (out_valid),
        .frame_status       (frame_status),
        .voltage_centivolts (voltage_centivolts),
        .charge_percent     (charge_percent),
        .low_battery        (low_battery)
    );

endmodule

`default_nettype wire

// ----- rtl/bmsrfc_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// bmsrfc_cfg_regs
// Configuration registers: voltage window and low charge level.
// ----------------------------------------------------------------------------
`default_nettype none

module bmsrfc_cfg_regs
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic [1:0]        cfg_index,
    input  wire logic [15:0]       cfg_wdata,
    output bmsrfc_pkg::cfg_t       cfg
);

    import bmsrfc_pkg::*;

    localparam logic [1:0] REG_VOLT_MIN  = 2'd0;
    localparam logic [1:0] REG_VOLT_MAX  = 2'd1;
    localparam logic [1:0] REG_LOW_LEVEL = 2'd2;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_VOLT_MIN:  cfg_next.volt_min  = cfg_wdata;
                REG_VOLT_MAX:  cfg_next.volt_max  = cfg_wdata;
                REG_LOW_LEVEL: cfg_next.low_level = cfg_wdata[7:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.volt_min  <= VOLT_MIN_RESET;
            cfg_reg.volt_max  <= VOLT_MAX_RESET;
            cfg_reg.low_level <= LOW_CHARGE_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ----- rtl/bmsrfc_frame_parser.sv -----
// ----------------------------------------------------------------------------
// bmsrfc_frame_parser
// Byte counter, running checksum and field capture for one reply frame.
// ----------------------------------------------------------------------------
`default_nettype none

module bmsrfc_frame_parser
#(
    parameter int MAX_FRAME_BYTES   = bmsrfc_pkg::MAX_FRAME_BYTES_DEF,
    parameter int CHARGE_BYTE_INDEX = bmsrfc_pkg::CHARGE_BYTE_INDEX_DEF
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   step,
    input  wire logic [7:0]             rx_byte,
    input  wire logic                   frame_start,
    output bmsrfc_pkg::frame_event_t    ev
);

    import bmsrfc_pkg::*;

    localparam int IDX_W = $clog2(MAX_FRAME_BYTES);
    localparam int CNT_W = 9;

    logic             active_reg, active_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [7:0]       len_reg, len_next;
    logic [7:0]       hdr_reg, hdr_next;
    logic [15:0]      sum_reg, sum_next;
    logic [15:0]      recent_reg, recent_next;
    logic [15:0]      volt_reg, volt_next;
    logic [7:0]       chg_reg, chg_next;

    logic [IDX_W-1:0] idx_cur;
    logic [7:0]       len_cur, hdr_cur, chg_cur;
    logic [15:0]      sum_cur, recent_cur, volt_cur;
    logic [CNT_W-1:0] idx_ext;
    logic [7:0]       len_new, hdr_new, chg_new;
    logic [15:0]      sum_new, volt_new, check;
    logic             too_long, in_sum, at_end;

    always_comb
    begin
        // a start byte sees a freshly cleared frame
        idx_cur    = frame_start ? '0     : idx_reg;
        len_cur    = frame_start ? 8'd0   : len_reg;
        hdr_cur    = frame_start ? 8'd0   : hdr_reg;
        sum_cur    = frame_start ? 16'd0  : sum_reg;
        recent_cur = frame_start ? 16'd0  : recent_reg;
        volt_cur   = frame_start ? 16'd0  : volt_reg;
        chg_cur    = frame_start ? 8'd0   : chg_reg;

        idx_ext  = CNT_W'(idx_cur);
        hdr_new  = (idx_ext == CNT_W'(0)) ? rx_byte : hdr_cur;
        len_new  = (idx_ext == CNT_W'(3)) ? rx_byte : len_cur;
        too_long = (idx_ext == CNT_W'(3))
                   && (({1'b0, rx_byte} + CNT_W'(7)) > CNT_W'(MAX_FRAME_BYTES));

        volt_new = volt_cur;
        if (idx_ext == CNT_W'(4))
        begin
            volt_new = {rx_byte, volt_cur[7:0]};
        end
        else if (idx_ext == CNT_W'(5))
        begin
            volt_new = {volt_cur[15:8], rx_byte};
        end

        chg_new = (idx_ext == CNT_W'(CHARGE_BYTE_INDEX)) ? rx_byte : chg_cur;
        in_sum  = (idx_ext >= CNT_W'(3)) && (idx_ext <= ({1'b0, len_new} + CNT_W'(3)));
        sum_new = in_sum ? (sum_cur + {8'd0, rx_byte}) : sum_cur;
        at_end  = (idx_ext >= CNT_W'(3)) && (idx_ext == ({1'b0, len_new} + CNT_W'(6)));
        check   = 16'd0 - sum_new;

        active_next = active_reg;
        idx_next    = idx_reg;
        len_next    = len_reg;
        hdr_next    = hdr_reg;
        sum_next    = sum_reg;
        recent_next = recent_reg;
        volt_next   = volt_reg;
        chg_next    = chg_reg;

        ev.fire   = 1'b0;
        ev.status = STATUS_GOOD;
        ev.volt   = volt_new;
        ev.charge = chg_new;

        if (step && (frame_start || active_reg))
        begin
            if (too_long)
            begin
                active_next = 1'b0;
                ev.fire     = 1'b1;
                ev.status   = STATUS_TOO_LONG;
            end
            else if (at_end)
            begin
                active_next = 1'b0;
                ev.fire     = 1'b1;
                if (hdr_new != HEADER_BYTE)
                begin
                    ev.status = STATUS_BAD_HEADER;
                end
                else if (check != recent_cur)
                begin
                    ev.status = STATUS_BAD_SUM;
                end
                else
                begin
                    ev.status = STATUS_GOOD;
                end
            end
            else
            begin
                active_next = 1'b1;
                idx_next    = idx_cur + 1'b1;
                len_next    = len_new;
                hdr_next    = hdr_new;
                sum_next    = sum_new;
                recent_next = {recent_cur[7:0], rx_byte};
                volt_next   = volt_new;
                chg_next    = chg_new;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            idx_reg    <= '0;
        end
        else
        begin
            active_reg <= active_next;
            idx_reg    <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg    <= len_next;
        hdr_reg    <= hdr_next;
        sum_reg    <= sum_next;
        recent_reg <= recent_next;
        volt_reg   <= volt_next;
        chg_reg    <= chg_next;
    end

endmodule

`default_nettype wire

// ----- rtl/bmsrfc_result_stage.sv -----
// ----------------------------------------------------------------------------
// bmsrfc_result_stage
// Kept voltage, charge filter and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module bmsrfc_result_stage
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       step,
    input  wire logic                       advance,
    input  wire bmsrfc_pkg::frame_event_t   ev,
    input  wire bmsrfc_pkg::cfg_t           cfg,
    output logic                            out_valid,
    output logic [1:0]                      frame_status,
    output logic [15:0]                     voltage_centivolts,
    output logic [7:0]                      charge_percent,
    output logic                            low_battery
);

    import bmsrfc_pkg::*;

    logic [15:0] volt_reg, volt_next;
    logic [7:0]  charge_reg, charge_next;
    logic [7:0]  prev_reg, prev_next;
    logic [1:0]  steady_reg, steady_next;
    logic [1:0]  steady_inc;
    logic signed [9:0] dc, dp;
    logic        near_kept, near_prev, emit;

    logic        out_valid_reg;
    logic [1:0]  status_reg;
    logic [15:0] out_volt_reg;
    logic [7:0]  out_charge_reg;
    logic        out_low_reg;

    assign emit = step && ev.fire;

    always_comb
    begin
        dc = $signed({2'b00, charge_reg}) - $signed({2'b00, ev.charge});
        dp = $signed({2'b00, prev_reg}) - $signed({2'b00, ev.charge});
        near_kept  = ((dc < 10'sd3) && ((-dc) < 10'sd5)) || (charge_reg == 8'd0);
        near_prev  = (dp < 10'sd2) && ((-dp) < 10'sd3);
        steady_inc = steady_reg + 2'd1;

        volt_next   = volt_reg;
        charge_next = charge_reg;
        prev_next   = prev_reg;
        steady_next = steady_reg;

        if (emit && (ev.status == STATUS_GOOD))
        begin
            if ((ev.volt > cfg.volt_min) && (ev.volt < cfg.volt_max))
            begin
                volt_next = ev.volt;
            end
            prev_next = ev.charge;
            if (near_kept)
            begin
                charge_next = ev.charge;
                steady_next = 2'd0;
            end
            else if (near_prev)
            begin
                // third steady reading since the last take-over takes over
                if (steady_inc == 2'd3)
                begin
                    charge_next = ev.charge;
                    steady_next = 2'd0;
                end
                else
                begin
                    steady_next = steady_inc;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            volt_reg      <= 16'd0;
            charge_reg    <= 8'd0;
            prev_reg      <= 8'd0;
            steady_reg    <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            volt_reg   <= volt_next;
            charge_reg <= charge_next;
            prev_reg   <= prev_next;
            steady_reg <= steady_next;
            if (advance)
            begin
                out_valid_reg <= emit;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            status_reg     <= ev.status;
            out_volt_reg   <= volt_next;
            out_charge_reg <= charge_next;
            out_low_reg    <= (charge_next < cfg.low_level);
        end
    end

    assign out_valid          = out_valid_reg;
    assign frame_status       = status_reg;
    assign voltage_centivolts = out_volt_reg;
    assign charge_percent     = out_charge_reg;
    assign low_battery        = out_low_reg;

endmodule

`default_nettype wire

// ----- rtl/bmsrfc_checker.sv -----
// ----------------------------------------------------------------------------
// bmsrfc_checker
// Port-level checks of the reply frame checker, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module bmsrfc_checker
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire logic        in_ready,
    input  wire logic [7:0]  rx_byte,
    input  wire logic        frame_start,
    input  wire logic        out_valid,
    input  wire logic        out_ready,
    input  wire logic [1:0]  frame_status,
    input  wire logic [15:0] voltage_centivolts,
    input  wire logic [7:0]  charge_percent,
    input  wire logic        low_battery,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_wdata
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(frame_status)
            && $stable(voltage_centivolts) && $stable(charge_percent)
            && $stable(low_battery))
        else $error("stalled result changed");

    // nothing pending on the output means input never stalls
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("in_ready low with empty output");

    a_ready_when_taken: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready |-> in_ready)
        else $error("in_ready low while result is taken");

    // a new result only comes from a cycle in which the pipe moved
    a_result_after_move: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_ready))
        else $error("result appeared without pipe advance");

endmodule

bind bms_reply_frame_checker_unit bmsrfc_checker u_bmsrfc_checker (.*);

`default_nettype wire
